[hw/rtl/iso2j_pkg.sv]
package iso2j_pkg;

  typedef enum logic [2:0] {
    SET_ASCII   = 3'd0,
    SET_LATIN   = 3'd1,
    SET_KANA    = 3'd2,
    SET_X0208A  = 3'd3,
    SET_X0208B  = 3'd4,
    SET_X0212   = 3'd5,
    SET_UNKNOWN = 3'd6
  } char_set_t;

  typedef enum logic [2:0] {
    KIND_ASCII = 3'd0,
    KIND_X0201 = 3'd1,
    KIND_X0208 = 3'd2,
    KIND_X0212 = 3'd3,
    KIND_REPL  = 3'd4
  } char_kind_t;

  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_SO     = 8'h0e;
  localparam logic [7:0] BYTE_SI     = 8'h0f;
  localparam logic [7:0] BYTE_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] BYTE_LPAREN = 8'h28;  // '('
  localparam logic [7:0] BYTE_AT     = 8'h40;  // '@'
  localparam logic [7:0] BYTE_B      = 8'h42;  // 'B'
  localparam logic [7:0] BYTE_D      = 8'h44;  // 'D'
  localparam logic [7:0] BYTE_I      = 8'h49;  // 'I'
  localparam logic [7:0] BYTE_J      = 8'h4a;  // 'J'
  localparam logic [14:0] CODE_REPL  = 15'h003f;  // '?'

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  char_kind;
    logic [14:0] char_code;
  } out_item_t;

  // escape intermediates: ( ) * + - . /
  function automatic logic is_intermediate(input logic [7:0] b);
    return b inside {8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2d, 8'h2e, 8'h2f};
  endfunction

endpackage

[hw/rtl/iso2022jp_escape_decoder_top.sv]
// ISO-2022-JP byte decoder: one byte per transaction on the in_ channel, at most one decoded
// character per transaction on the out_ channel (escape, SO/SI and first bytes of two-byte
// codes produce none). Throughput is one byte per clock while out_ready holds; a byte passes
// from the input register through a single pass of decode logic into the result register.
// A stalled output holds back decoding of the next byte, so in_ready drops only when both
// registers are full. Asserting start_of_text with a byte returns the decoder to ASCII with no
// escape or pending byte before that byte is decoded.
module iso2022jp_escape_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iso2j_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iso2j_pkg::out_item_t out_data
);
  import iso2j_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  char_set_t cur_set_r, cur_set_nxt;
  char_set_t saved_set_r, saved_set_nxt;
  logic      esc_r, esc_nxt;
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;

  logic      advance;
  logic      res_valid;
  out_item_t res;

  char_set_t  cur;
  char_set_t  sav;
  logic       esc;
  logic [1:0] hc;
  logic [7:0] b;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    b   = s1_data_r.byte_in;
    cur = s1_data_r.start_of_text ? SET_ASCII : cur_set_r;
    sav = s1_data_r.start_of_text ? SET_ASCII : saved_set_r;
    esc = s1_data_r.start_of_text ? 1'b0 : esc_r;
    hc  = s1_data_r.start_of_text ? 2'd0 : held_cnt_r;

    cur_set_nxt   = cur;
    saved_set_nxt = sav;
    esc_nxt       = esc;
    held_cnt_nxt  = hc;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    res_valid     = 1'b0;
    res.char_kind = KIND_REPL;
    res.char_code = CODE_REPL;

    if (esc) begin
      cur_set_nxt  = SET_UNKNOWN;
      esc_nxt      = 1'b0;
      held_cnt_nxt = 2'd0;
      case (hc)
        2'd0: begin
          if (b == BYTE_DOLLAR || is_intermediate(b)) begin
            held0_nxt    = b;
            held_cnt_nxt = 2'd1;
            esc_nxt      = 1'b1;
          end
        end
        2'd1: begin
          if (held0_r == BYTE_DOLLAR) begin
            if (is_intermediate(b)) begin
              held1_nxt    = b;
              held_cnt_nxt = 2'd2;
              esc_nxt      = 1'b1;
            end else if (b == BYTE_AT) begin
              cur_set_nxt = SET_X0208A;
            end else if (b == BYTE_B) begin
              cur_set_nxt = SET_X0208B;
            end
          end else if (held0_r == BYTE_LPAREN) begin
            if (b == BYTE_B) cur_set_nxt = SET_ASCII;
            else if (b == BYTE_I) cur_set_nxt = SET_KANA;
            else if (b == BYTE_J) cur_set_nxt = SET_LATIN;
          end
        end
        2'd2: begin
          if (held1_r == BYTE_LPAREN && b == BYTE_D) cur_set_nxt = SET_X0212;
        end
        default: begin
        end
      endcase
    end else if (b == BYTE_ESC) begin
      held_cnt_nxt = 2'd0;
      esc_nxt      = 1'b1;
    end else if (b == BYTE_SO) begin
      saved_set_nxt = cur;
      cur_set_nxt   = SET_KANA;
      held_cnt_nxt  = 2'd0;
    end else if (b == BYTE_SI) begin
      cur_set_nxt  = (sav == SET_ASCII || sav == SET_LATIN) ? sav : SET_ASCII;
      held_cnt_nxt = 2'd0;
    end else if (hc != 2'd0) begin
      held_cnt_nxt = 2'd0;
      res_valid    = 1'b1;
      if (cur == SET_X0208A || cur == SET_X0208B) begin
        res.char_kind = KIND_X0208;
        res.char_code = {held0_r[6:0], 1'b0, b[6:0]};
      end else if (cur == SET_X0212) begin
        res.char_kind = KIND_X0212;
        res.char_code = {held0_r[6:0], 1'b0, b[6:0]};
      end
    end else if (cur == SET_X0208A || cur == SET_X0208B || cur == SET_X0212) begin
      held0_nxt    = b;
      held_cnt_nxt = 2'd1;
    end else begin
      res_valid = 1'b1;
      if (cur == SET_ASCII && !b[7]) begin
        res.char_kind = KIND_ASCII;
        res.char_code = {7'd0, b};
      end else if (cur == SET_ASCII || cur == SET_LATIN) begin
        res.char_kind = KIND_X0201;
        res.char_code = {7'd0, b};
      end else if (cur == SET_KANA) begin
        res.char_kind = KIND_X0201;
        res.char_code = {7'd0, 1'b1, b[6:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_set_r   <= SET_ASCII;
      saved_set_r <= SET_ASCII;
      esc_r       <= 1'b0;
      held_cnt_r  <= 2'd0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) out_valid_r <= s1_valid_r && res_valid;
      if (advance && s1_valid_r) begin
        cur_set_r   <= cur_set_nxt;
        saved_set_r <= saved_set_nxt;
        esc_r       <= esc_nxt;
        held_cnt_r  <= held_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_data_r <= in_data;
    if (advance && s1_valid_r) begin
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
      out_data_r <= res;
    end
  end

endmodule

[tb/iso2022jp_escape_decoder_top_tb.sv]
module iso2022jp_escape_decoder_top_tb;
  import iso2j_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // shadow of the decoder state
  char_set_t  cur_set;
  char_set_t  shift_saved_set;
  bit         in_escape;
  logic [1:0] pend_count;
  logic [7:0] pend_bytes [2];

  out_item_t expected_chars [$];

  int send_idle_pct = 8;
  int recv_idle_pct = 67;
  int err_count     = 0;
  int bytes_sent    = 0;
  int chars_seen    = 0;
  int stall_cycles  = 0;

  iso2022jp_escape_decoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_esc_mid(input logic [7:0] b);
    case (b)
      8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2d, 8'h2e, 8'h2f: return 1'b1;  // ( ) * + - . /
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_double_set(input char_set_t s);
    return s == SET_X0208A || s == SET_X0208B || s == SET_X0212;
  endfunction

  function automatic void push_char(input char_kind_t kind, input logic [14:0] code);
    out_item_t item;
    item.char_kind = kind;
    item.char_code = code;
    expected_chars.push_back(item);
  endfunction

  function automatic void clear_decoder();
    cur_set         = SET_ASCII;
    shift_saved_set = SET_ASCII;
    in_escape       = 1'b0;
    pend_count      = 2'd0;
  endfunction

  function automatic void close_escape();
    in_escape  = 1'b0;
    pend_count = 2'd0;
  endfunction

  function automatic void track_escape(input logic [7:0] b);
    cur_set = SET_UNKNOWN;
    if (pend_count == 2'd0) begin
      if (b == BYTE_DOLLAR || is_esc_mid(b)) begin
        pend_bytes[0] = b;
        pend_count    = 2'd1;
      end else begin
        close_escape();
      end
    end else if (pend_count == 2'd1) begin
      if (pend_bytes[0] == BYTE_DOLLAR && is_esc_mid(b)) begin
        pend_bytes[1] = b;
        pend_count    = 2'd2;
        return;
      end
      if (pend_bytes[0] == BYTE_DOLLAR) begin
        if (b == BYTE_AT) cur_set = SET_X0208A;
        else if (b == BYTE_B) cur_set = SET_X0208B;
      end else if (pend_bytes[0] == BYTE_LPAREN) begin
        if (b == BYTE_B) cur_set = SET_ASCII;
        else if (b == BYTE_I) cur_set = SET_KANA;
        else if (b == BYTE_J) cur_set = SET_LATIN;
      end
      close_escape();
    end else begin
      if (pend_count == 2'd2 && pend_bytes[1] == BYTE_LPAREN && b == BYTE_D)
        cur_set = SET_X0212;
      close_escape();
    end
  endfunction

  function automatic void decode_byte(input in_item_t it);
    logic [7:0]  b;
    logic [14:0] pair;
    b = it.byte_in;
    if (it.start_of_text) clear_decoder();
    if (in_escape) begin
      track_escape(b);
    end else if (b == BYTE_ESC) begin
      pend_count = 2'd0;
      in_escape  = 1'b1;
    end else if (b == BYTE_SO) begin
      shift_saved_set = cur_set;
      cur_set         = SET_KANA;
      pend_count      = 2'd0;
    end else if (b == BYTE_SI) begin
      cur_set = (shift_saved_set == SET_ASCII || shift_saved_set == SET_LATIN) ?
                shift_saved_set : SET_ASCII;
      pend_count = 2'd0;
    end else if (pend_count != 2'd0) begin
      pair       = {pend_bytes[0][6:0], 1'b0, b[6:0]};
      pend_count = 2'd0;
      if (cur_set == SET_X0208A || cur_set == SET_X0208B) push_char(KIND_X0208, pair);
      else if (cur_set == SET_X0212) push_char(KIND_X0212, pair);
      else push_char(KIND_REPL, CODE_REPL);
    end else if (is_double_set(cur_set)) begin
      pend_bytes[0] = b;
      pend_count    = 2'd1;
    end else if (cur_set == SET_ASCII && !b[7]) begin
      push_char(KIND_ASCII, {7'd0, b});
    end else if (cur_set == SET_ASCII || cur_set == SET_LATIN) begin
      push_char(KIND_X0201, {7'd0, b});
    end else if (cur_set == SET_KANA) begin
      push_char(KIND_X0201, {7'd0, b | 8'h80});
    end else begin
      push_char(KIND_REPL, CODE_REPL);
    end
  endfunction

  // ---------------------------------------------------------------- driver

  task automatic send_byte(input logic [7:0] b, input logic sot);
    in_item_t it;
    it.byte_in       = b;
    it.start_of_text = sot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(it);
    bytes_sent++;
  endtask

  task automatic send_esc2(input logic [7:0] b1, input logic [7:0] b2);
    send_byte(BYTE_ESC, 1'b0);
    send_byte(b1, 1'b0);
    send_byte(b2, 1'b0);
  endtask

  // one character per unit: a pair of bytes in the two-byte sets
  task automatic send_text(input int units);
    logic [7:0] b;
    int         n;
    repeat (units) begin
      n = is_double_set(cur_set) ? 2 : 1;
      repeat (n) begin
        b = 8'($urandom_range(255));
        if (b == BYTE_ESC || b == BYTE_SO || b == BYTE_SI) b = 8'($urandom_range(8'h7e, 8'h20));
        send_byte(b, 1'b0);
      end
    end
  endtask

  function automatic logic [7:0] escape_noise();
    case ($urandom_range(10))
      0: return BYTE_DOLLAR;
      1: return BYTE_LPAREN;
      2: return 8'h29;
      3: return BYTE_AT;
      4: return BYTE_B;
      5: return BYTE_D;
      6: return BYTE_I;
      7: return BYTE_J;
      8: return 8'h00;
      9: return BYTE_ESC;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_chars
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected char: char_kind %0d char_code 0x%04h",
               out_data.char_kind, out_data.char_code);
        err_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.char_kind !== want.char_kind) begin
          $error("char_kind: expected %0d, actual %0d", want.char_kind, out_data.char_kind);
          err_count++;
        end
        if (out_data.char_code !== want.char_code) begin
          $error("char_code: expected 0x%04h, actual 0x%04h",
                 want.char_code, out_data.char_code);
          err_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_single_byte_sets();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);          // high byte while in ASCII
    send_esc2(BYTE_LPAREN, BYTE_J);
    send_byte(8'h80, 1'b0);
    send_esc2(BYTE_LPAREN, BYTE_I);
    send_byte(8'h7f, 1'b0);
  endtask

  task automatic test_shift_codes();
    // saved set is Kana, so SI falls back to ASCII
    send_byte(BYTE_SO, 1'b0);
    send_byte(BYTE_SI, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_two_byte_sets();
    send_esc2(BYTE_DOLLAR, BYTE_AT);
    send_byte(8'h21, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(BYTE_ESC, 1'b0);
    send_esc2(BYTE_DOLLAR, BYTE_LPAREN);
    send_byte(BYTE_D, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_bad_escapes();
    send_byte(BYTE_ESC, 1'b0);
    send_byte(8'h00, 1'b0);          // zero ends the escape, set is unknown
    send_byte(8'h41, 1'b0);
    send_byte(8'h30, 1'b1);          // start of text leaves the unknown set
  endtask

  task automatic test_random_stream(input int target);
    int k;
    while (bytes_sent < target) begin
      k = $urandom_range(99);
      if (k < 40) begin
        case ($urandom_range(5))
          0: send_esc2(BYTE_LPAREN, BYTE_B);
          1: send_esc2(BYTE_LPAREN, BYTE_J);
          2: send_esc2(BYTE_LPAREN, BYTE_I);
          3: send_esc2(BYTE_DOLLAR, BYTE_AT);
          4: send_esc2(BYTE_DOLLAR, BYTE_B);
          default: begin
            send_esc2(BYTE_DOLLAR, BYTE_LPAREN);
            send_byte(BYTE_D, 1'b0);
          end
        endcase
        send_text($urandom_range(6, 1));
      end else if (k < 50) begin
        send_byte(BYTE_SO, 1'b0);
        send_text($urandom_range(3));
        send_byte(BYTE_SI, 1'b0);
        send_text($urandom_range(2));
      end else if (k < 65) begin
        send_byte(BYTE_ESC, 1'b0);
        repeat ($urandom_range(3, 1)) send_byte(escape_noise(), 1'b0);
        send_text($urandom_range(2));
      end else if (k < 85) begin
        send_text($urandom_range(4, 1));
      end else if (k < 95) begin
        send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        send_byte(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  initial begin
    clear_decoder();
    pend_bytes[0] = 8'h00;
    pend_bytes[1] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 8;
    recv_idle_pct = 67;
    test_single_byte_sets();
    test_shift_codes();
    test_two_byte_sets();
    test_bad_escapes();
    test_random_stream(500);

    send_idle_pct = 67;
    recv_idle_pct = 8;
    test_random_stream(975);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(1450);

    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decoded %0d bytes into %0d checked characters", bytes_sent, chars_seen);
    $display("covered all designations, SO/SI, broken escapes and start-of-text resets");
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
